[rtl/core/wsd_pkg.sv]
`default_nettype none

package wsd_pkg;

  // extended length register width
  localparam int unsigned LENGTH_WIDTH = 64;

  // depth of the command queue between parser and output stage (power of two)
  localparam int unsigned QUEUE_DEPTH = 2;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_CLOSE   = 2'd2;

  // header constants
  localparam logic [3:0] OPC_CLOSE      = 4'h8;
  localparam logic [6:0] LEN7_EXT_SHORT = 7'd126;
  localparam logic [6:0] LEN7_EXT_LONG  = 7'd127;
  localparam logic [3:0] EXT_BYTES_SHORT = 4'd2;
  localparam logic [3:0] EXT_BYTES_LONG  = 4'd8;
  localparam logic [3:0] KEY_BYTES       = 4'd4;

  // one classified result, handed from the parser to the output stage
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
    logic [1:0] kind;
    logic [3:0] opcode;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/core/websocket_frame_deframer.sv]
// each result is written into the command queue, then loaded into the output register that presents it
// throughput: one byte per cycle while the queue has room, set by the header parser and
//   the 64-bit length decrement in its payload phase
// a 2-entry command queue and the output register keep input flowing while a result waits
// reset (rst_ni, async, active low) returns the parser to waiting for a first header byte
//   and empties the queue and output register
`default_nettype none

module websocket_frame_deframer #(
  parameter int unsigned LengthWidth = wsd_pkg::LENGTH_WIDTH,
  parameter int unsigned QueueDepth  = wsd_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // byte stream in
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  // results out
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      payload_byte_o,
  output logic            last_in_frame_o,
  output logic [1:0]      result_kind_o,
  output logic [3:0]      frame_opcode_o
);

  logic          accept;
  logic          push;
  logic          q_full;
  logic          q_valid;
  logic          pop;
  wsd_pkg::cmd_t front_cmd;
  wsd_pkg::cmd_t q_cmd;

  // take a byte whenever the queue has room, whatever the parse phase
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  // front: header parsing, length tracking, key byte selection
  wsd_front #(
    .LengthWidth(LengthWidth)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_byte_i(in_byte_i),
    .cmd_o    (front_cmd),
    .push_o   (push)
  );

  // short queue decoupling the parser from output stalls
  wsd_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .full_o (q_full),
    .valid_o(q_valid),
    .cmd_o  (q_cmd),
    .pop_i  (pop)
  );

  // back: unmasking and the registered output transfer
  wsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_byte_o (payload_byte_o),
    .last_in_frame_o(last_in_frame_o),
    .result_kind_o  (result_kind_o),
    .frame_opcode_o (frame_opcode_o)
  );

endmodule

`default_nettype wire

[rtl/core/wsd_front.sv]
`default_nettype none

module wsd_front #(
  parameter int unsigned LengthWidth = wsd_pkg::LENGTH_WIDTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [7:0]   in_byte_i,
  output wsd_pkg::cmd_t     cmd_o,
  output logic              push_o
);

  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_SECOND  = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]             phase_q, phase_d;
  logic [3:0]             hcnt_q, hcnt_d;
  logic [3:0]             opc_q, opc_d;
  logic                   mask_q, mask_d;
  logic                   ext_long_q, ext_long_d;
  logic [31:0]            key_q, key_d;
  logic [LengthWidth-1:0] rem_q, rem_d;
  logic [1:0]             kidx_q, kidx_d;

  logic [3:0]             hcnt_inc;
  logic [3:0]             ext_needed;
  logic [6:0]             len7;
  logic [LengthWidth-1:0] rem_shift;
  logic [7:0]             key_sel;

  assign hcnt_inc   = hcnt_q + 4'd1;
  assign ext_needed = ext_long_q ? wsd_pkg::EXT_BYTES_LONG : wsd_pkg::EXT_BYTES_SHORT;
  assign len7       = in_byte_i[6:0];
  assign rem_shift  = {rem_q[LengthWidth-9:0], in_byte_i};

  always_comb begin
    case (kidx_q)
      2'd0:    key_sel = key_q[31:24];
      2'd1:    key_sel = key_q[23:16];
      2'd2:    key_sel = key_q[15:8];
      default: key_sel = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    hcnt_d     = hcnt_q;
    opc_d      = opc_q;
    mask_d     = mask_q;
    ext_long_d = ext_long_q;
    key_d      = key_q;
    rem_d      = rem_q;
    kidx_d     = kidx_q;
    push_o     = 1'b0;
    cmd_o      = '{data: 8'd0, key: 8'd0, last: 1'b1,
                   kind: wsd_pkg::KIND_EMPTY, opcode: opc_q};

    case (phase_q)
      PH_SECOND: begin
        if (opc_q == wsd_pkg::OPC_CLOSE) begin
          phase_d    = PH_FIRST;
          push_o     = 1'b1;
          cmd_o.kind = wsd_pkg::KIND_CLOSE;
        end else begin
          mask_d = in_byte_i[7];
          hcnt_d = 4'd0;
          if (len7 == wsd_pkg::LEN7_EXT_SHORT || len7 == wsd_pkg::LEN7_EXT_LONG) begin
            ext_long_d = (len7 == wsd_pkg::LEN7_EXT_LONG);
            rem_d      = '0;
            phase_d    = PH_EXTLEN;
          end else begin
            rem_d  = {{(LengthWidth-7){1'b0}}, len7};
            kidx_d = 2'd0;
            if (in_byte_i[7]) begin
              phase_d = PH_KEY;
            end else if (len7 == 7'd0) begin
              phase_d = PH_FIRST;
              push_o  = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
      end
      PH_EXTLEN: begin
        rem_d  = rem_shift;
        hcnt_d = hcnt_inc;
        if (hcnt_inc >= ext_needed) begin
          hcnt_d = 4'd0;
          kidx_d = 2'd0;
          if (mask_q) begin
            phase_d = PH_KEY;
          end else if (rem_shift == '0) begin
            phase_d = PH_FIRST;
            push_o  = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_KEY: begin
        key_d  = {key_q[23:0], in_byte_i};
        hcnt_d = hcnt_inc;
        if (hcnt_inc >= wsd_pkg::KEY_BYTES) begin
          hcnt_d = 4'd0;
          kidx_d = 2'd0;
          if (rem_q == '0) begin
            phase_d = PH_FIRST;
            push_o  = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        kidx_d     = kidx_q + 2'd1;
        rem_d      = rem_q - {{(LengthWidth-1){1'b0}}, 1'b1};
        push_o     = 1'b1;
        cmd_o.data = in_byte_i;
        cmd_o.key  = mask_q ? key_sel : 8'd0;
        cmd_o.kind = wsd_pkg::KIND_PAYLOAD;
        // count reaches zero after this byte
        cmd_o.last = (rem_q == {{(LengthWidth-1){1'b0}}, 1'b1});
        if (cmd_o.last) begin
          phase_d = PH_FIRST;
        end
      end
      default: begin
        opc_d   = in_byte_i[3:0];
        hcnt_d  = 4'd0;
        phase_d = PH_SECOND;
      end
    endcase

    if (!accept_i) begin
      push_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_FIRST;
      hcnt_q     <= 4'd0;
      opc_q      <= 4'd0;
      mask_q     <= 1'b0;
      ext_long_q <= 1'b0;
      key_q      <= 32'd0;
      rem_q      <= '0;
      kidx_q     <= 2'd0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      hcnt_q     <= hcnt_d;
      opc_q      <= opc_d;
      mask_q     <= mask_d;
      ext_long_q <= ext_long_d;
      key_q      <= key_d;
      rem_q      <= rem_d;
      kidx_q     <= kidx_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/wsd_queue.sv]
`default_nettype none

module wsd_queue #(
  parameter int unsigned Depth = wsd_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire wsd_pkg::cmd_t cmd_i,
  output logic               full_o,
  output logic               valid_o,
  output wsd_pkg::cmd_t      cmd_o,
  input  wire logic          pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  wsd_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == DepthCnt);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt)
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count lost a write");

endmodule

`default_nettype wire

[rtl/core/wsd_back.sv]
`default_nettype none

module wsd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire wsd_pkg::cmd_t q_cmd_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       payload_byte_o,
  output logic             last_in_frame_o,
  output logic [1:0]       result_kind_o,
  output logic [3:0]       frame_opcode_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q;
  logic [1:0] kind_q;
  logic [3:0] opc_q;

  // load the output register whenever the queue holds a result and the register is empty or being drained
  assign pop_o = q_valid_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= q_cmd_i.data ^ q_cmd_i.key;
      last_q <= q_cmd_i.last;
      kind_q <= q_cmd_i.kind;
      opc_q  <= q_cmd_i.opcode;
    end
  end

  assign out_valid_o     = valid_q;
  assign payload_byte_o  = data_q;
  assign last_in_frame_o = last_q;
  assign result_kind_o   = kind_q;
  assign frame_opcode_o  = opc_q;

  a_close_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == wsd_pkg::KIND_CLOSE) |->
      (last_q && data_q == 8'd0 && opc_q == wsd_pkg::OPC_CLOSE))
    else $error("close result malformed");

  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == wsd_pkg::KIND_EMPTY) |-> (last_q && data_q == 8'd0))
    else $error("empty-frame result malformed");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

[sim/tb_websocket_frame_deframer.sv]
typedef enum logic [2:0] {
  HDR_FIRST,
  HDR_SECOND,
  HDR_EXTLEN,
  HDR_KEY,
  BODY
} frame_phase_e;

typedef struct packed {
  logic [7:0] data;
  logic       last;
  logic [1:0] kind;
  logic [3:0] opcode;
} deframed_result_t;

// tracks the frame parser state byte by byte and checks the block's results
class frame_tracker;
  frame_phase_e                      phase;
  logic [3:0]                        opcode;
  logic                              mask_on;
  logic [31:0]                       mask_key;
  logic [wsd_pkg::LENGTH_WIDTH-1:0]  bytes_left;
  logic [1:0]                        key_pos;
  logic [3:0]                        hdr_count;
  logic [3:0]                        ext_total;
  deframed_result_t                  pending[$];
  int unsigned                       failures;

  function new();
    phase      = HDR_FIRST;
    opcode     = '0;
    mask_on    = 1'b0;
    mask_key   = '0;
    bytes_left = '0;
    key_pos    = '0;
    hdr_count  = '0;
    ext_total  = '0;
    failures   = 0;
  endfunction

  function void queue_result(logic [7:0] data, logic last, logic [1:0] kind,
                             logic [3:0] opc);
    deframed_result_t r;
    r.data   = data;
    r.last   = last;
    r.kind   = kind;
    r.opcode = opc;
    pending.push_back(r);
  endfunction

  // length known: go on to the key, to the payload, or end an empty frame
  function void header_complete();
    hdr_count = '0;
    key_pos   = '0;
    if (mask_on) begin
      phase = HDR_KEY;
    end else if (bytes_left == 0) begin
      phase = HDR_FIRST;
      queue_result(8'h00, 1'b1, wsd_pkg::KIND_EMPTY, opcode);
    end else begin
      phase = BODY;
    end
  endfunction

  function void note_rx_byte(logic [7:0] b);
    logic [7:0] key_byte;
    logic [7:0] data;
    case (phase)
      HDR_SECOND: begin
        if (opcode == wsd_pkg::OPC_CLOSE) begin
          // close ends right here, anything after it is a new header
          phase = HDR_FIRST;
          queue_result(8'h00, 1'b1, wsd_pkg::KIND_CLOSE, wsd_pkg::OPC_CLOSE);
        end else begin
          mask_on   = b[7];
          hdr_count = '0;
          if (b[6:0] == wsd_pkg::LEN7_EXT_SHORT || b[6:0] == wsd_pkg::LEN7_EXT_LONG) begin
            ext_total  = (b[6:0] == wsd_pkg::LEN7_EXT_SHORT) ? wsd_pkg::EXT_BYTES_SHORT
                                                             : wsd_pkg::EXT_BYTES_LONG;
            bytes_left = '0;
            phase      = HDR_EXTLEN;
          end else begin
            bytes_left = {{(wsd_pkg::LENGTH_WIDTH-7){1'b0}}, b[6:0]};
            header_complete();
          end
        end
      end
      HDR_EXTLEN: begin
        bytes_left = (bytes_left << 8) | b;
        hdr_count  = hdr_count + 1'b1;
        if (hdr_count >= ext_total) header_complete();
      end
      HDR_KEY: begin
        mask_key  = {mask_key[23:0], b};
        hdr_count = hdr_count + 1'b1;
        if (hdr_count >= wsd_pkg::KEY_BYTES) begin
          hdr_count = '0;
          key_pos   = '0;
          if (bytes_left == 0) begin
            phase = HDR_FIRST;
            queue_result(8'h00, 1'b1, wsd_pkg::KIND_EMPTY, opcode);
          end else begin
            phase = BODY;
          end
        end
      end
      BODY: begin
        key_byte = 8'(mask_key >> (24 - 8 * key_pos));
        data     = mask_on ? (b ^ key_byte) : b;
        key_pos  = key_pos + 1'b1;
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0) phase = HDR_FIRST;
        queue_result(data, bytes_left == 0, wsd_pkg::KIND_PAYLOAD, opcode);
      end
      default: begin
        opcode    = b[3:0];
        hdr_count = '0;
        phase     = HDR_SECOND;
      end
    endcase
  endfunction

  function void check_output(logic [7:0] data, logic last, logic [1:0] kind,
                             logic [3:0] opc);
    deframed_result_t want;
    if (pending.size() == 0) begin
      $error("result with nothing pending: payload_byte %02h kind %0d opcode %0h",
             data, kind, opc);
      failures++;
      return;
    end
    want = pending.pop_front();
    if (data !== want.data) begin
      $error("payload_byte: expected %02h, got %02h", want.data, data);
      failures++;
    end
    if (last !== want.last) begin
      $error("last_in_frame: expected %0b, got %0b", want.last, last);
      failures++;
    end
    if (kind !== want.kind) begin
      $error("result_kind: expected %0d, got %0d", want.kind, kind);
      failures++;
    end
    if (opc !== want.opcode) begin
      $error("frame_opcode: expected %0h, got %0h", want.opcode, opc);
      failures++;
    end
  endfunction
endclass

module tb_websocket_frame_deframer;

  localparam int unsigned RANDOM_BYTES = 1950;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] payload_byte_o;
  logic       last_in_frame_o;
  logic [1:0] result_kind_o;
  logic [3:0] frame_opcode_o;

  frame_tracker tracker = new();
  logic [7:0]   rx_stream[$];
  int unsigned  cycle_count = 0;

  // short hand-picked stream: full first byte, masked byte, close with a
  // stray length code, zero 16-bit length, 64-bit length carrying one byte
  logic [7:0] directed_seq [26] = '{
    8'hFF, 8'h00,
    8'h82, 8'h81, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'hFF,
    8'h88, 8'hFE,
    8'h81, 8'h7E, 8'h00, 8'h00,
    8'h00, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00
  };

  websocket_frame_deframer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .payload_byte_o  (payload_byte_o),
    .last_in_frame_o (last_in_frame_o),
    .result_kind_o   (result_kind_o),
    .frame_opcode_o  (frame_opcode_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_websocket_frame_deframer failed");
      $finish;
    end
  end

  // one well-formed frame with random header bits, mask and content;
  // close frames get a random second byte
  task automatic add_random_frame();
    logic [7:0]  first;
    logic        mask_bit;
    int unsigned len;
    int unsigned pick;
    first = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) first[3:0] = wsd_pkg::OPC_CLOSE;
    rx_stream.push_back(first);
    if (first[3:0] == wsd_pkg::OPC_CLOSE) begin
      rx_stream.push_back(8'($urandom_range(0, 255)));
      return;
    end
    mask_bit = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 6) len = $urandom_range(0, 12);
    else if (pick == 6) len = $urandom_range(13, 125);
    else if (pick == 7) len = $urandom_range(0, 40);
    else if (pick == 8) len = $urandom_range(0, 300);
    else len = $urandom_range(0, 20);
    if (pick < 7) begin
      rx_stream.push_back({mask_bit, 7'(len)});
    end else if (pick < 9) begin
      rx_stream.push_back({mask_bit, wsd_pkg::LEN7_EXT_SHORT});
      rx_stream.push_back(8'(len >> 8));
      rx_stream.push_back(8'(len));
    end else begin
      rx_stream.push_back({mask_bit, wsd_pkg::LEN7_EXT_LONG});
      for (int i = 7; i >= 0; i--) rx_stream.push_back(8'(64'(len) >> (8 * i)));
    end
    if (mask_bit) repeat (4) rx_stream.push_back(8'($urandom_range(0, 255)));
    repeat (len) rx_stream.push_back(8'($urandom_range(0, 255)));
  endtask

  // hold the byte until its transfer, return at the following falling edge
  task automatic send_byte(logic [7:0] b);
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_rx_byte(b);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned burst;
    int unsigned gap;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_seq[i]) rx_stream.push_back(directed_seq[i]);
    while (rx_stream.size() < RANDOM_BYTES + $size(directed_seq)) add_random_frame();

    // bursts of random length separated by random gaps, some back to back
    while (rx_stream.size() > 0) begin
      burst = $urandom_range(1, 48);
      while (burst > 0 && rx_stream.size() > 0) begin
        send_byte(rx_stream.pop_front());
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("tb_websocket_frame_deframer passed");
    end else begin
      $display("tb_websocket_frame_deframer failed");
    end
    $finish;
  end

  // receiver alternates between always ready, random, periodic and long stalls
  initial begin : result_pacing
    int unsigned mode;
    int unsigned span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (int unsigned tick = 0; tick < span; tick++) begin
        @(negedge clk_i);
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= (tick % 4 != 3);
          default: out_ready_i <= ((tick / 12) % 2 == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_output(payload_byte_o, last_in_frame_o, result_kind_o, frame_opcode_o);
    end
  end

endmodule
